// File: hdl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held low.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Clocked property that also holds through reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/ppdw_pkg.sv
// ----------------------------------------------------------------------------
// ppdw_pkg
// Shared types and constants of the periodic pair distance and weight pipeline.
// ----------------------------------------------------------------------------
package ppdw_pkg;

    // Control that travels alongside every pipeline stage
    typedef struct packed {
        logic valid;
        logic err;
    } ctl_t;

    // Terms of the exp(-f) series and the integer exponent cut-off
    localparam int unsigned EXP_TERMS = 20;
    localparam int unsigned EXP_CUT   = 40;

    // One in Q1.31
    localparam logic [31:0] Q31_ONE = 32'h8000_0000;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BOX_SIZE   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INV_LENGTH = 2'd1;

    // exp(-1) in Q1.31 by the truncated Horner series, evaluated at elaboration
    function automatic logic [31:0] exp_neg_one();
        logic [63:0] r;
        r = 64'h8000_0000;
        for (int k = EXP_TERMS; k >= 1; k--) begin
            r = 64'h8000_0000 - r / 64'(k);
        end
        return r[31:0];
    endfunction

    localparam logic [31:0] E_NEG_ONE = exp_neg_one();

endpackage

// File: hdl/periodic_pair_distance_weight.sv
// ----------------------------------------------------------------------------
// periodic_pair_distance_weight
// Minimum-image distance of a particle pair in a periodic square box and its
// exponential interaction weight, as a fully pipelined stream block.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  s_       in         s_tvalid / s_tready       s_tdata: four coordinates
//  m_       out        m_tvalid / m_tready       m_tdata: distance, weight;
//                                                m_tuser: range error
//  cfg_     in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One pair per clock while no result is held at the output. The pipeline is
// formed by the remainder chain, the root chain, the 40-stage exp series and the
// 39-stage exp(-1) power chain.
// Reset clears all valid bits and loads the register defaults.
// A held result freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module periodic_pair_distance_weight #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 16
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // first_x, first_y, second_x, second_y
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]           s_tdata,

    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // distance, weight
    output logic [((COORD_BITS+FRAC_BITS+8)/8)*8-1:0]   m_tdata,
    // range_error
    output logic [0:0]                                  m_tuser,

    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [ppdw_pkg::CFG_INDEX_BITS-1:0]         cfg_index,
    input  logic [COORD_BITS-1:0]                       cfg_data
);

    localparam int MW = ((COORD_BITS + FRAC_BITS + 8) / 8) * 8;
    localparam logic [COORD_BITS-1:0] BOX_RESET = COORD_BITS'(64'd100 << FRAC_BITS);
    localparam logic [COORD_BITS-1:0] INV_RESET = COORD_BITS'(64'd1 << FRAC_BITS);

    logic [COORD_BITS-1:0] box_reg;
    logic [COORD_BITS-1:0] inv_reg;
    logic                  adv;

    logic [COORD_BITS-1:0] ax, ay, bx, by;
    ppdw_pkg::ctl_t        in_ctl, wrap_ctl, root_ctl, out_ctl;
    logic [COORD_BITS-1:0] mag_x, mag_y, root_distance, out_dist;
    logic [FRAC_BITS:0]    weight;

    // Write configuration registers; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_reg <= BOX_RESET;
            inv_reg <= INV_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ppdw_pkg::REG_BOX_SIZE:   box_reg <= cfg_data;
                ppdw_pkg::REG_INV_LENGTH: inv_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the whole pipeline unless a result is held at the output
    assign adv      = !out_ctl.valid || m_tready;
    assign s_tready = adv;

    // Unpack the input transaction and flag coordinates outside the box
    assign ax = s_tdata[COORD_BITS-1:0];
    assign ay = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign bx = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign by = s_tdata[4*COORD_BITS-1:3*COORD_BITS];

    assign in_ctl.valid = s_tvalid;
    assign in_ctl.err   = (ax >= box_reg) || (ay >= box_reg) ||
                          (bx >= box_reg) || (by >= box_reg);

    ppdw_wrap #(.COORD_BITS(COORD_BITS)) u_wrap (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_ctl   (in_ctl),
        .first_x  (ax),
        .first_y  (ay),
        .second_x (bx),
        .second_y (by),
        .box      (box_reg),
        .out_ctl  (wrap_ctl),
        .mag_x    (mag_x),
        .mag_y    (mag_y)
    );

    ppdw_root #(.COORD_BITS(COORD_BITS)) u_root (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_ctl   (wrap_ctl),
        .mag_x    (mag_x),
        .mag_y    (mag_y),
        .out_ctl  (root_ctl),
        .distance (root_distance)
    );

    ppdw_weight #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_weight (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_ctl   (root_ctl),
        .distance (root_distance),
        .inv_len  (inv_reg),
        .out_ctl  (out_ctl),
        .out_dist (out_dist),
        .weight   (weight)
    );

    // Pack the result transaction
    assign m_tvalid   = out_ctl.valid;
    assign m_tdata    = MW'({weight, out_dist});
    assign m_tuser[0] = out_ctl.err;

endmodule

// File: hdl/ppdw_wrap.sv
// ----------------------------------------------------------------------------
// ppdw_wrap
// Minimum-image offset magnitude for both axes: a restoring remainder chain,
// one quotient bit per stage, then a fold about the half box.
// ----------------------------------------------------------------------------
module ppdw_wrap #(
    parameter int COORD_BITS = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  ppdw_pkg::ctl_t        in_ctl,
    input  logic [COORD_BITS-1:0] first_x,
    input  logic [COORD_BITS-1:0] first_y,
    input  logic [COORD_BITS-1:0] second_x,
    input  logic [COORD_BITS-1:0] second_y,
    input  logic [COORD_BITS-1:0] box,
    output ppdw_pkg::ctl_t        out_ctl,
    output logic [COORD_BITS-1:0] mag_x,
    output logic [COORD_BITS-1:0] mag_y
);

    localparam int TW = COORD_BITS + 1;    // magnitude of the shifted difference
    localparam int NS = COORD_BITS + 3;    // prep, TW remainder steps, fold

    ppdw_pkg::ctl_t        ctl_reg [0:NS-1];
    logic [COORD_BITS-1:0] half;
    logic [COORD_BITS-1:0] a_in [0:1];
    logic [COORD_BITS-1:0] b_in [0:1];
    logic [COORD_BITS-1:0] mag_out [0:1];

    assign half  = box >> 1;
    assign a_in[0] = first_x;
    assign a_in[1] = first_y;
    assign b_in[0] = second_x;
    assign b_in[1] = second_y;

    // Advance the control chain
    for (genvar j = 0; j < NS; j++) begin : g_ctl
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[j].valid <= 1'b0;
            end else if (adv) begin
                if (j == 0) begin
                    ctl_reg[j] <= in_ctl;
                end else begin
                    ctl_reg[j] <= ctl_reg[(j > 0) ? j - 1 : 0];
                end
            end
        end
    end

    for (genvar g = 0; g < 2; g++) begin : g_lane
        logic [TW-1:0]         rem_reg [0:NS-2];
        logic                  neg_reg [0:NS-2];
        logic [COORD_BITS-1:0] mag_reg;
        logic [COORD_BITS+1:0] diff;
        logic [TW-1:0]         abs_next;

        // Shift the difference by half a box and split into sign and magnitude
        assign diff = {2'b00, a_in[g]} - {2'b00, b_in[g]} + {2'b00, half};
        assign abs_next = diff[COORD_BITS+1] ? TW'(-diff) : TW'(diff);

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[0] <= abs_next;
                neg_reg[0] <= diff[COORD_BITS+1];
            end
        end

        // One restoring remainder step per stage, highest quotient bit first
        for (genvar j = 1; j < NS - 1; j++) begin : g_step
            localparam int SH = NS - 2 - j;
            logic [TW-1:0] rem_next;
            logic          take;

            assign take     = (rem_reg[j-1] >> SH) >= TW'(box);
            assign rem_next = take ? rem_reg[j-1] - (TW'(box) << SH) : rem_reg[j-1];

            always_ff @(posedge aclk) begin
                if (adv) begin
                    rem_reg[j] <= rem_next;
                    neg_reg[j] <= neg_reg[j-1];
                end
            end
        end

        // Fold the positive remainder about the half box
        logic [COORD_BITS-1:0] m;
        logic [COORD_BITS-1:0] r;
        logic [COORD_BITS-1:0] mag_next;

        assign m = rem_reg[NS-2][COORD_BITS-1:0];
        assign r = (neg_reg[NS-2] && (m != '0)) ? box - m : m;

        always_comb begin
            if (box == '0) begin
                mag_next = '0;
            end else if (r >= half) begin
                mag_next = r - half;
            end else begin
                mag_next = half - r;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                mag_reg <= mag_next;
            end
        end

        assign mag_out[g] = mag_reg;
    end

    assign out_ctl = ctl_reg[NS-1];
    assign mag_x   = mag_out[0];
    assign mag_y   = mag_out[1];

endmodule

// File: hdl/ppdw_root.sv
// ----------------------------------------------------------------------------
// ppdw_root
// Sum of squared offsets and its integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module ppdw_root #(
    parameter int COORD_BITS = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  ppdw_pkg::ctl_t        in_ctl,
    input  logic [COORD_BITS-1:0] mag_x,
    input  logic [COORD_BITS-1:0] mag_y,
    output ppdw_pkg::ctl_t        out_ctl,
    output logic [COORD_BITS-1:0] distance
);

    localparam int PW = 2 * COORD_BITS;
    localparam int RW = COORD_BITS + 3;
    localparam int NS = COORD_BITS + 2;   // squares, sum, root steps

    ppdw_pkg::ctl_t        ctl_reg [0:NS-1];
    logic [PW-1:0]         sqx_reg;
    logic [PW-1:0]         sqy_reg;
    logic [PW-1:0]         rad_reg  [1:NS-1];
    logic [RW-1:0]         rem_reg  [2:NS-1];
    logic [COORD_BITS-1:0] root_reg [2:NS-1];

    // Advance the control chain
    for (genvar j = 0; j < NS; j++) begin : g_ctl
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[j].valid <= 1'b0;
            end else if (adv) begin
                if (j == 0) begin
                    ctl_reg[j] <= in_ctl;
                end else begin
                    ctl_reg[j] <= ctl_reg[(j > 0) ? j - 1 : 0];
                end
            end
        end
    end

    // Square each offset, then add
    always_ff @(posedge aclk) begin
        if (adv) begin
            sqx_reg    <= PW'(mag_x) * PW'(mag_x);
            sqy_reg    <= PW'(mag_y) * PW'(mag_y);
            rad_reg[1] <= sqx_reg + sqy_reg;
        end
    end

    // Digit-by-digit square root, two radicand bits per stage
    for (genvar j = 2; j < NS; j++) begin : g_step
        logic [RW-1:0]         rem_in;
        logic [COORD_BITS-1:0] root_in;
        logic [RW-1:0]         rem_w;
        logic [RW-1:0]         trial;
        logic                  ge;

        if (j == 2) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_chain
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
        end

        assign rem_w = RW'({rem_in, rad_reg[j-1][PW-1 -: 2]});
        assign trial = RW'({root_in, 2'b01});
        assign ge    = rem_w >= trial;

        always_ff @(posedge aclk) begin
            if (adv) begin
                rad_reg[j]  <= {rad_reg[j-1][PW-3:0], 2'b00};
                rem_reg[j]  <= ge ? rem_w - trial : rem_w;
                root_reg[j] <= {root_in[COORD_BITS-2:0], ge};
            end
        end
    end

    assign out_ctl  = ctl_reg[NS-1];
    assign distance = root_reg[NS-1];

endmodule

// File: hdl/ppdw_weight.sv
// ----------------------------------------------------------------------------
// ppdw_weight
// Weight exp(-distance * inv_length): product and split, a Horner series for
// the fraction, a chain of exp(-1) multiplications for the integer part.
// ----------------------------------------------------------------------------
module ppdw_weight #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  ppdw_pkg::ctl_t        in_ctl,
    input  logic [COORD_BITS-1:0] distance,
    input  logic [COORD_BITS-1:0] inv_len,
    output ppdw_pkg::ctl_t        out_ctl,
    output logic [COORD_BITS-1:0] out_dist,
    output logic [FRAC_BITS:0]    weight
);

    localparam int PW  = 2 * COORD_BITS;
    localparam int NW  = (PW - 2 * FRAC_BITS > 0) ? PW - 2 * FRAC_BITS : 1;
    localparam int NXW = (NW > 7) ? NW : 7;
    localparam int HS  = 2 * ppdw_pkg::EXP_TERMS;
    localparam int PS  = ppdw_pkg::EXP_CUT - 1;
    localparam int WW  = FRAC_BITS + 1;

    // Product and split stages
    ppdw_pkg::ctl_t        ctl_p_reg, ctl_s_reg;
    logic [PW-1:0]         p_reg;
    logic [COORD_BITS-1:0] dist_p_reg, dist_s_reg;
    logic [31:0]           f_s_reg;
    logic [5:0]            n_s_reg;
    logic                  cut_s_reg;

    logic [2*FRAC_BITS+31:0] f_wide;
    logic [NXW-1:0]          n_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_p_reg.valid <= 1'b0;
            ctl_s_reg.valid <= 1'b0;
        end else if (adv) begin
            ctl_p_reg <= in_ctl;
            ctl_s_reg <= ctl_p_reg;
        end
    end

    assign f_wide = {p_reg[2*FRAC_BITS-1:0], 32'b0};
    assign n_ext  = NXW'(NW'(p_reg >> (2 * FRAC_BITS)));

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_reg      <= PW'(distance) * PW'(inv_len);
            dist_p_reg <= distance;
            f_s_reg    <= f_wide[2*FRAC_BITS+31:2*FRAC_BITS];
            n_s_reg    <= 6'(n_ext);
            cut_s_reg  <= n_ext >= NXW'(ppdw_pkg::EXP_CUT);
            dist_s_reg <= dist_p_reg;
        end
    end

    // Horner series for exp(-f): even stages multiply, odd stages divide by k
    ppdw_pkg::ctl_t        hctl_reg  [0:HS-1];
    logic [31:0]           hf_reg    [0:HS-1];
    logic [31:0]           hval_reg  [0:HS-1];
    logic [5:0]            hn_reg    [0:HS-1];
    logic                  hcut_reg  [0:HS-1];
    logic [COORD_BITS-1:0] hdist_reg [0:HS-1];

    for (genvar t = 0; t < HS; t++) begin : g_horner
        ppdw_pkg::ctl_t        ctl_in;
        logic [31:0]           f_in;
        logic [31:0]           val_in;
        logic [5:0]            n_in;
        logic                  cut_in;
        logic [COORD_BITS-1:0] dist_in;
        logic [31:0]           val_next;

        if (t == 0) begin : g_first
            assign ctl_in  = ctl_s_reg;
            assign f_in    = f_s_reg;
            assign val_in  = ppdw_pkg::Q31_ONE;
            assign n_in    = n_s_reg;
            assign cut_in  = cut_s_reg;
            assign dist_in = dist_s_reg;
        end else begin : g_chain
            assign ctl_in  = hctl_reg[t-1];
            assign f_in    = hf_reg[t-1];
            assign val_in  = hval_reg[t-1];
            assign n_in    = hn_reg[t-1];
            assign cut_in  = hcut_reg[t-1];
            assign dist_in = hdist_reg[t-1];
        end

        if (t % 2 == 0) begin : g_mul
            logic [63:0] prod;
            assign prod     = 64'(f_in) * 64'(val_in);
            assign val_next = prod[63:32];
        end else begin : g_div
            // Exact floor division by k through a rounded-up reciprocal
            localparam int unsigned K = ppdw_pkg::EXP_TERMS - t / 2;
            localparam int unsigned L = $clog2(K);
            localparam logic [32:0] M =
                33'(((64'd1 << (32 + L)) + 64'(K) - 64'd1) / 64'(K));
            logic [64:0] qprod;
            assign qprod    = 65'(val_in) * 65'(M);
            assign val_next = ppdw_pkg::Q31_ONE - 32'(qprod >> (32 + L));
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                hctl_reg[t].valid <= 1'b0;
            end else if (adv) begin
                hctl_reg[t] <= ctl_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                hf_reg[t]    <= f_in;
                hval_reg[t]  <= val_next;
                hn_reg[t]    <= n_in;
                hcut_reg[t]  <= cut_in;
                hdist_reg[t] <= dist_in;
            end
        end
    end

    // exp(-n): one truncated multiplication by exp(-1) per stage while below n
    ppdw_pkg::ctl_t        pctl_reg  [0:PS-1];
    logic [31:0]           ptot_reg  [0:PS-1];
    logic [5:0]            pn_reg    [0:PS-1];
    logic                  pcut_reg  [0:PS-1];
    logic [COORD_BITS-1:0] pdist_reg [0:PS-1];

    for (genvar i = 0; i < PS; i++) begin : g_power
        ppdw_pkg::ctl_t        ctl_in;
        logic [31:0]           tot_in;
        logic [5:0]            n_in;
        logic                  cut_in;
        logic [COORD_BITS-1:0] dist_in;
        logic [63:0]           prod;
        logic [31:0]           tot_next;

        if (i == 0) begin : g_first
            assign ctl_in  = hctl_reg[HS-1];
            assign tot_in  = hval_reg[HS-1];
            assign n_in    = hn_reg[HS-1];
            assign cut_in  = hcut_reg[HS-1];
            assign dist_in = hdist_reg[HS-1];
        end else begin : g_chain
            assign ctl_in  = pctl_reg[i-1];
            assign tot_in  = ptot_reg[i-1];
            assign n_in    = pn_reg[i-1];
            assign cut_in  = pcut_reg[i-1];
            assign dist_in = pdist_reg[i-1];
        end

        assign prod     = 64'(tot_in) * 64'(ppdw_pkg::E_NEG_ONE);
        assign tot_next = (6'(i) < n_in) ? 32'(prod >> 31) : tot_in;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pctl_reg[i].valid <= 1'b0;
            end else if (adv) begin
                pctl_reg[i] <= ctl_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                ptot_reg[i]  <= tot_next;
                pn_reg[i]    <= n_in;
                pcut_reg[i]  <= cut_in;
                pdist_reg[i] <= dist_in;
            end
        end
    end

    // Round half up to the output precision, zero beyond the cut-off
    ppdw_pkg::ctl_t        ctl_o_reg;
    logic [WW-1:0]         weight_reg;
    logic [COORD_BITS-1:0] dist_o_reg;
    logic [32:0]           rsum;
    logic [WW-1:0]         weight_next;

    assign rsum        = {1'b0, ptot_reg[PS-1]} + (33'd1 << (30 - FRAC_BITS));
    assign weight_next = pcut_reg[PS-1] ? '0 : WW'(rsum >> (31 - FRAC_BITS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_o_reg.valid <= 1'b0;
        end else if (adv) begin
            ctl_o_reg <= pctl_reg[PS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            weight_reg <= weight_next;
            dist_o_reg <= pdist_reg[PS-1];
        end
    end

    assign out_ctl  = ctl_o_reg;
    assign out_dist = dist_o_reg;
    assign weight   = weight_reg;

endmodule

// File: hdl/ppdw_checker.sv
// ----------------------------------------------------------------------------
// ppdw_checker
// Port-level checks of the pair distance and weight block, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppdw_checker #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 16
) (
    input logic                                      aclk,
    input logic                                      aresetn,
    input logic                                      s_tready,
    input logic                                      m_tvalid,
    input logic                                      m_tready,
    input logic [((COORD_BITS+FRAC_BITS+8)/8)*8-1:0] m_tdata
);

    localparam logic [FRAC_BITS:0] W_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    // Hold a result that has not been taken
    `ASSERT_CLK(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // Reset empties the pipeline
    `ASSERT_CLK_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result after reset")

    // Accept input whenever the output is empty
    `ASSERT_CLK(a_ready, aclk, aresetn, !m_tvalid |-> s_tready, "input blocked with empty output")

    // Weight never exceeds one, and zero distance gives exactly one
    `ASSERT_CLK(a_wmax, aclk, aresetn, m_tvalid |-> m_tdata[COORD_BITS+FRAC_BITS:COORD_BITS] <= W_ONE, "weight above one")
    `ASSERT_CLK(a_wzero, aclk, aresetn, m_tvalid && m_tdata[COORD_BITS-1:0] == '0 |-> m_tdata[COORD_BITS+FRAC_BITS:COORD_BITS] == W_ONE, "zero distance weight")

endmodule

bind periodic_pair_distance_weight ppdw_checker #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
) u_ppdw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/sv/periodic_pair_distance_weight_tb.sv
// ----------------------------------------------------------------------------
// periodic_pair_distance_weight_tb
// Streams coordinate pairs through the pair distance block under several box
// and decay settings, predicts distance, weight and range flag per pair, and
// compares every result in order. Both sides idle in random bursts, and the
// receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module periodic_pair_distance_weight_tb;

    localparam int CB       = 24;
    localparam int FB       = 16;
    localparam int LATENCY  = 2*CB + 87;
    localparam int WD_LIMIT = 6000;
    localparam int LONG_HOLD = 500;

    // Index that addresses no register
    localparam logic [ppdw_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [CB-1:0] fx, fy, sx, sy;
    } pair_t;

    typedef struct packed {
        logic [CB-1:0] distance;
        logic [FB:0]   weight;
        logic          range_err;
    } pair_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [95:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [0:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [ppdw_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CB-1:0] cfg_data = '0;

    periodic_pair_distance_weight uut (.*);

    // Predictor copy of the registers
    logic [CB-1:0] box_q = 24'd6553600;
    logic [CB-1:0] inv_q = 24'd65536;

    pair_t     pending_pairs[$];
    pair_res_t expected_res[$];
    int n_sent = 0, n_recv = 0, n_mism = 0, n_extra = 0;
    bit quiet = 1'b0, send_pause = 1'b0;

    initial forever #1 aclk = ~aclk;

    // exp(-f) in Q1.31, f in Q.32, truncated Horner series
    function automatic longint unsigned exp_frac(longint unsigned f);
        longint unsigned r;
        r = 64'h8000_0000;
        for (int k = ppdw_pkg::EXP_TERMS; k >= 1; k--)
            r = 64'h8000_0000 - ((f * r) >> 32) / longint'(k);
        return r;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned wrapped_offset(longint unsigned a, longint unsigned b);
        longint bx, half, t, r;
        bx = longint'(box_q);
        half = longint'(box_q >> 1);
        if (bx == 0) return 0;
        t = longint'(a) - longint'(b) + half;
        r = t % bx;
        if (r < 0) r += bx;
        r = r - half;
        return (r < 0) ? -r : r;
    endfunction

    function automatic pair_res_t pair_distance_weight(pair_t p);
        pair_res_t o;
        longint unsigned mx, my, d, prod, n, f32, total, e1;
        mx = wrapped_offset(p.fx, p.sx);
        my = wrapped_offset(p.fy, p.sy);
        d = int_sqrt(mx * mx + my * my) & 64'hFF_FFFF;
        prod = d * inv_q;
        n = prod >> 32;
        f32 = prod & 64'hFFFF_FFFF;
        o.distance = d[CB-1:0];
        if (n >= ppdw_pkg::EXP_CUT) begin
            o.weight = '0;
        end else begin
            total = exp_frac(f32);
            e1 = exp_frac(64'd1 << 32);
            for (longint unsigned i = 0; i < n; i++)
                total = (total * e1) >> 31;
            total = (total + (64'd1 << (30 - FB))) >> (31 - FB);
            o.weight = total[FB:0];
        end
        o.range_err = (p.fx >= box_q) || (p.fy >= box_q) ||
                      (p.sx >= box_q) || (p.sy >= box_q);
        return o;
    endfunction

    // Driver: present queued pairs, predict on each accepted transaction
    int tx_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_res.push_back(pair_distance_weight(pending_pairs[0]));
                void'(pending_pairs.pop_front());
                n_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_pairs.size() == 0 || send_pause) begin
                    s_tvalid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 5) == 0) begin
                    tx_gap = $urandom_range(1, 10) - 1;
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {pending_pairs[0].sy, pending_pairs[0].sx,
                                 pending_pairs[0].fy, pending_pairs[0].fx};
                end
            end
        end
    end

    // Monitor: compare results in order, idle and hold off the result side
    int rx_gap = 0, rx_hold = 0;
    bit hold_done = 1'b0;
    always @(posedge aclk) begin
        pair_res_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.distance = m_tdata[CB-1:0];
                got.weight = m_tdata[CB+FB:CB];
                got.range_err = m_tuser[0];
                n_recv++;
                if (expected_res.size() == 0) begin
                    n_extra++;
                    n_mism++;
                    if (n_mism <= 10)
                        $display("unexpected result: dist %0d weight %0d err %0d",
                                 got.distance, got.weight, got.range_err);
                end else begin
                    want = expected_res.pop_front();
                    if (got != want) begin
                        n_mism++;
                        if (n_mism <= 10)
                            $display({"mismatch #%0d: dist exp %0d got %0d, ",
                                      "weight exp %0d got %0d, err exp %0d got %0d"},
                                     n_recv, want.distance, got.distance,
                                     want.weight, got.weight,
                                     want.range_err, got.range_err);
                    end
                end
            end
            if (!hold_done && n_recv == 600) begin
                hold_done = 1'b1;
                rx_hold = LONG_HOLD;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                rx_gap = $urandom_range(1, 10) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any transaction
    int stuck = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stuck = 0;
        else
            stuck++;
        if (stuck >= WD_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WD_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [ppdw_pkg::CFG_INDEX_BITS-1:0] idx, logic [CB-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == ppdw_pkg::REG_BOX_SIZE) box_q = val;
        else if (idx == ppdw_pkg::REG_INV_LENGTH) inv_q = val;
    endtask

    // Wait until every pair has been answered, then let the pipe empty
    task automatic drain();
        while (pending_pairs.size() != 0 || expected_res.size() != 0 || s_tvalid)
            @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    function automatic logic [CB-1:0] rand_coord();
        int unsigned m;
        m = $urandom_range(0, 19);
        if (m == 0) return CB'($urandom());                    // anywhere, often out of box
        if (m == 1) return box_q;                              // just out of range
        if (m == 2) return (box_q == '0) ? '0 : box_q - 1'b1;  // top edge
        if (m == 3) return '0;
        if (box_q == '0) return CB'($urandom());
        return CB'($urandom_range(0, box_q - 1));
    endfunction

    task automatic queue_random(int count);
        pair_t p;
        repeat (count) begin
            p.fx = rand_coord();
            p.fy = rand_coord();
            // half the time keep the pair close so weights stay non-zero
            if ($urandom_range(0, 1) == 0 && box_q > 16) begin
                p.sx = CB'(p.fx + $urandom_range(0, 3*65536) - 3*32768);
                p.sy = CB'(p.fy + $urandom_range(0, 3*65536) - 3*32768);
            end else begin
                p.sx = rand_coord();
                p.sy = rand_coord();
            end
            pending_pairs.push_back(p);
        end
    endtask

    task automatic queue_pair(logic [CB-1:0] a, b, c, d);
        pair_t p;
        p.fx = a; p.fy = b; p.sx = c; p.sy = d;
        pending_pairs.push_back(p);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed pairs under the reset settings
        queue_pair(24'd0, 24'd0, 24'd0, 24'd0);
        queue_pair(24'd6553599, 24'd6553599, 24'd0, 24'd0);     // wrap across the edge
        queue_pair(24'd3276800, 24'd0, 24'd0, 24'd0);           // exactly half the box
        queue_pair(24'd3276799, 24'd3276801, 24'd0, 24'd0);
        queue_pair(24'd1000000, 24'd2000000, 24'd1000000, 24'd2000000);
        queue_pair(24'd3276800, 24'd3276800, 24'd0, 24'd0);     // far apart: weight cut to zero
        queue_pair(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        queue_pair(24'hFFFFFF, 24'd0, 24'd0, 24'hFFFFFF);       // outside the box
        queue_pair(24'd6553600, 24'd1, 24'd2, 24'd3);
        queue_pair(24'h555555, 24'hAAAAAA, 24'h2AAAAA, 24'h155555);
        queue_pair(24'd65536, 24'd0, 24'd0, 24'd0);             // distance one
        queue_pair(24'd2621440, 24'd0, 24'd0, 24'd0);           // 40 decay lengths
        queue_pair(24'd2621439, 24'd0, 24'd0, 24'd0);
        drain();

        // Odd box, largest decay rate, ignored index
        write_reg(ppdw_pkg::REG_BOX_SIZE, 24'd131073);
        write_reg(ppdw_pkg::REG_INV_LENGTH, 24'hFFFFFF);
        write_reg(REG_UNUSED, 24'h123456);
        queue_pair(24'd65536, 24'd0, 24'd0, 24'd0);
        queue_pair(24'd1, 24'd0, 24'd0, 24'd0);
        queue_pair(24'd131072, 24'd131073, 24'd0, 24'd0);
        queue_random(300);
        drain();

        // Largest box, slow decay; long receiver hold falls here
        write_reg(ppdw_pkg::REG_BOX_SIZE, 24'hFFFFFF);
        write_reg(ppdw_pkg::REG_INV_LENGTH, 24'd1);
        queue_random(450);
        drain();

        // One-unit box, zero inverse length
        write_reg(ppdw_pkg::REG_BOX_SIZE, 24'd65536);
        write_reg(ppdw_pkg::REG_INV_LENGTH, 24'd0);
        queue_random(150);
        drain();

        // Zero box
        write_reg(ppdw_pkg::REG_BOX_SIZE, 24'd0);
        write_reg(ppdw_pkg::REG_INV_LENGTH, 24'd65536);
        queue_random(100);
        drain();

        // Back to a mid box with a random rate
        write_reg(ppdw_pkg::REG_BOX_SIZE, 24'd6553600);
        write_reg(ppdw_pkg::REG_INV_LENGTH, CB'($urandom_range(16384, 262144)));
        queue_random(400);
        while (pending_pairs.size() > 150) @(posedge aclk);
        // sender pauses until every answer is in
        send_pause = 1'b1;
        while (expected_res.size() != 0) @(posedge aclk);
        send_pause = 1'b0;
        drain();

        // Random box and rate, final part without idling
        write_reg(ppdw_pkg::REG_BOX_SIZE, CB'($urandom_range(65536, 24'hFFFFFF)));
        write_reg(ppdw_pkg::REG_INV_LENGTH, CB'($urandom_range(1, 24'hFFFFFF)));
        queue_random(480);
        while (pending_pairs.size() > 200) @(posedge aclk);
        quiet = 1'b1;
        drain();

        $display("covered %0d pairs over seven box/decay settings, %0d results checked",
                 n_sent, n_recv);
        $display("mismatches %0d, unexpected results %0d", n_mism, n_extra);
        if (n_mism == 0 && expected_res.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
